// ----- design/tcts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcts_pkg
// Shared types and constants of the content type sniffer: class codes,
// character codes and the per-item state record.
// ----------------------------------------------------------------------------
package tcts_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned CLASS_W = 4;
    localparam int unsigned LEN_W   = 3;

    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [CH_W-1:0]    t_char;
    typedef logic [LEN_W-1:0]   t_len;

    // Content class codes.
    localparam t_class CLS_NONE         = 4'd0;
    localparam t_class CLS_BOOL         = 4'd1;
    localparam t_class CLS_CLASSREF     = 4'd2;
    localparam t_class CLS_INT          = 4'd3;
    localparam t_class CLS_DOUBLE       = 4'd4;
    localparam t_class CLS_STRING       = 4'd5;
    localparam t_class CLS_LIST_OFFSET  = 4'd5;
    localparam t_class CLS_QUADVEC      = 4'd11;
    localparam t_class CLS_QUADVEC_LIST = 4'd12;

    // Character codes.
    localparam t_char CH_HASH   = 8'h23;
    localparam t_char CH_LPAREN = 8'h28;
    localparam t_char CH_RPAREN = 8'h29;
    localparam t_char CH_DOT    = 8'h2E;
    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_NL     = 8'h0A;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_ZERO   = 8'h30;
    localparam t_char CH_NINE   = 8'h39;
    localparam t_char CH_T      = 8'h74;
    localparam t_char CH_F      = 8'h66;

    localparam t_len LEN_MAX   = 3'd7;
    localparam t_len TRUE_LEN  = 3'd4;
    localparam t_len FALSE_LEN = 3'd5;

    // Sniffer state carried from one item to the next.
    typedef struct packed {
        t_class detect_class;
        logic   in_token;
        logic   list_pending;
        logic   bool_polarity;
        t_len   token_length;
        logic   confirmed;
    } t_state;

    localparam t_state STATE_RESET = '{
        detect_class:  CLS_NONE,
        in_token:      1'b0,
        list_pending:  1'b0,
        bool_polarity: 1'b0,
        token_length:  '0,
        confirmed:     1'b0
    };

    // Keyword character at a given position ("true" or "false").
    function automatic t_char kw_char(input logic polarity, input t_len pos);
        t_char c;
        c = 8'h00;
        if (polarity) begin
            case (pos)
                3'd0:    c = 8'h74; // t
                3'd1:    c = 8'h72; // r
                3'd2:    c = 8'h75; // u
                3'd3:    c = 8'h65; // e
                default: c = 8'h00;
            endcase
        end else begin
            case (pos)
                3'd0:    c = 8'h66; // f
                3'd1:    c = 8'h61; // a
                3'd2:    c = 8'h6C; // l
                3'd3:    c = 8'h73; // s
                3'd4:    c = 8'h65; // e
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

endpackage

// ----- design/tcts_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcts_step
// Next-state logic of the sniffer for one character.
// ----------------------------------------------------------------------------
module tcts_step
    import tcts_pkg::*;
(
    input  t_state i_state,
    input  t_char  i_ch,
    output t_state o_state
);

    logic   is_space;
    logic   is_digit;
    logic   kw_ok;
    t_len   kw_len;
    t_state s;

    assign is_space = (i_ch == CH_NL) || (i_ch == CH_SPACE) || (i_ch == CH_TAB);
    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign kw_len   = i_state.bool_polarity ? TRUE_LEN : FALSE_LEN;
    assign kw_ok    = (i_state.token_length < kw_len) &&
                      (kw_char(i_state.bool_polarity, i_state.token_length) == i_ch);

    always_comb begin
        s = i_state;
        if (!i_state.confirmed) begin
            if (!i_state.in_token) begin
                if (!is_space) begin
                    s.in_token = 1'b1;
                    if (i_state.list_pending) begin
                        // A second token turns the candidate into its list form.
                        if (i_state.detect_class < CLS_QUADVEC) begin
                            s.detect_class = i_state.detect_class + CLS_LIST_OFFSET;
                        end else if (i_state.detect_class == CLS_QUADVEC) begin
                            s.detect_class = CLS_QUADVEC_LIST;
                        end
                        s.confirmed = 1'b1;
                    end else begin
                        s.token_length = 3'd1;
                        if (i_ch == CH_T) begin
                            s.bool_polarity = 1'b1;
                            s.detect_class  = CLS_BOOL;
                        end else if (i_ch == CH_F) begin
                            s.bool_polarity = 1'b0;
                            s.detect_class  = CLS_BOOL;
                        end else if (i_ch == CH_MINUS || is_digit) begin
                            s.detect_class = CLS_INT;
                        end else if (i_ch == CH_HASH) begin
                            s.detect_class = CLS_CLASSREF;
                        end else if (i_ch == CH_LPAREN) begin
                            s.detect_class = CLS_QUADVEC;
                        end else begin
                            s.detect_class = CLS_STRING;
                        end
                    end
                end
            end else if (i_state.detect_class == CLS_QUADVEC) begin
                // Only the closing parenthesis ends a quad vector token.
                if (i_ch == CH_RPAREN) begin
                    s.in_token     = 1'b0;
                    s.token_length = '0;
                    s.list_pending = 1'b1;
                end
            end else if (is_space) begin
                s.in_token     = 1'b0;
                s.token_length = '0;
                s.list_pending = 1'b1;
            end else begin
                case (i_state.detect_class)
                    CLS_BOOL: begin
                        if (!kw_ok) begin
                            s.detect_class = CLS_STRING;
                        end
                    end
                    CLS_INT: begin
                        if (i_ch == CH_DOT) begin
                            s.detect_class = CLS_DOUBLE;
                        end else if (!is_digit) begin
                            s.detect_class = CLS_STRING;
                        end
                    end
                    CLS_DOUBLE: begin
                        if (!is_digit) begin
                            s.detect_class = CLS_STRING;
                        end
                    end
                    default: begin
                    end
                endcase
                if (i_state.token_length < LEN_MAX) begin
                    s.token_length = i_state.token_length + 3'd1;
                end
            end
        end
    end

    assign o_state = s;

endmodule

// ----- design/tag_content_type_sniffer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_content_type_sniffer_top
// Classifies a text value streamed one character per item.
// ----------------------------------------------------------------------------
// The block takes one character item per clock and reports the content class
// (none, bool, class reference, integer, decimal, string, quad vector, or a
// list of one of these) once, for the item flagged last, after which it
// returns to its reset state for the next value. Each character is captured
// in an input register, from which the classification state is updated by
// a short piece of combinational logic; the class of a last item is loaded
// into an output register. Items are accepted back to back at one per clock
// while no stall holds them. The only stall comes from the output side:
// a last item waits in the input register while an earlier class has not
// been taken, and the input then stops accepting until the output register
// frees up.
// ----------------------------------------------------------------------------
module tag_content_type_sniffer_top
    import tcts_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [7:0]   i_ch,
    input  logic         i_last,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [3:0]   o_content_class
);

    // Input register.
    logic   r_in_valid;
    t_char  r_ch;
    logic   r_last;

    // Classification state.
    t_state r_state;
    t_state n_state;

    // Output register.
    logic   r_out_valid;
    t_class r_class;

    logic   out_free;
    logic   advance;

    // A character without the last flag produces no result and always moves
    // on; a last character needs a free output register.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_last || out_free);
    assign o_in_ready = !r_in_valid || advance;

    tcts_step u_step (
        .i_state (r_state),
        .i_ch    (r_ch),
        .o_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                // The value ends with a last item: state returns to reset.
                r_state <= r_last ? STATE_RESET : n_state;
            end
            if (advance && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_ch   <= i_ch;
            r_last <= i_last;
        end
        if (advance && r_last) begin
            r_class <= n_state.detect_class;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_content_class = r_class;

endmodule
